### sv/gclt_pkg.sv
// shared types, constants and codes for the g-code line tokenizer
`default_nettype none
package gclt_pkg;

  localparam int LETTER_SLOTS  = 26;
  localparam int MANTISSA_BITS = 32;

  localparam int MAG_W     = (MANTISSA_BITS < 32) ? MANTISSA_BITS - 1 : 31;
  localparam int ACC_EXT_W = MAG_W + 4;
  localparam int CODE_W    = 16;
  localparam int CODE_EXT_W = CODE_W + 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_G     = 8'd71;
  localparam logic [7:0] CH_M     = 8'd77;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_POINT = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_A     = 8'd65;

  localparam logic [1:0] KIND_CMD_OK   = 2'd0;
  localparam logic [1:0] KIND_CMD_REJ  = 2'd1;
  localparam logic [1:0] KIND_PARAM    = 2'd2;
  localparam logic [1:0] KIND_BARE_EOL = 2'd3;

  typedef enum logic [3:0] {
    CMD_G00, CMD_G01, CMD_G04, CMD_G90, CMD_G91, CMD_G92,
    CMD_M03, CMD_M05, CMD_M07, CMD_M09, CMD_M10, CMD_M11,
    CMD_M14, CMD_M15, CMD_M98, CMD_M99
  } cmd_t;

  typedef enum logic [2:0] {
    PH_FIRST, PH_CODE_LEAD, PH_CODE_DIGITS, PH_PARAM_LETTER, PH_PARAM_LEAD, PH_PARAM_BODY
  } phase_t;

  typedef enum logic [1:0] {
    CL_NONE, CL_G, CL_M, CL_OTHER
  } letter_t;

  typedef struct packed {
    logic       is_space;
    logic       is_ws;
    logic       is_plus;
    logic       is_minus;
    logic       is_point;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_g;
    logic       is_m;
    logic       slot_ok;
    logic [4:0] slot;
    logic       eol;
  } char_class_t;

endpackage
`default_nettype wire

### sv/gclt_front.sv
// front end: classifies each incoming character word
`default_nettype none
module gclt_front (
  input  wire logic [7:0]          char_in,
  input  wire logic                line_end,
  output gclt_pkg::char_class_t    cls
);

  logic [7:0] rel;

  assign rel = char_in - gclt_pkg::CH_A;

  always_comb begin
    cls.is_space = (char_in == gclt_pkg::CH_SPACE);
    cls.is_ws    = (char_in >= gclt_pkg::CH_TAB) && (char_in <= gclt_pkg::CH_CR);
    cls.is_plus  = (char_in == gclt_pkg::CH_PLUS);
    cls.is_minus = (char_in == gclt_pkg::CH_MINUS);
    cls.is_point = (char_in == gclt_pkg::CH_POINT);
    cls.is_digit = (char_in >= gclt_pkg::CH_ZERO) && (char_in <= gclt_pkg::CH_NINE);
    cls.digit    = 4'(char_in - gclt_pkg::CH_ZERO);
    cls.is_g     = (char_in == gclt_pkg::CH_G);
    cls.is_m     = (char_in == gclt_pkg::CH_M);
    cls.slot_ok  = (char_in >= gclt_pkg::CH_A) &&
                   (rel < 8'(gclt_pkg::LETTER_SLOTS));
    cls.slot     = rel[4:0];
    cls.eol      = line_end;
  end

endmodule
`default_nettype wire

### sv/gclt_queue.sv
// short queue of classified words between front and back
`default_nettype none
module gclt_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire gclt_pkg::char_class_t push_word,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       head_valid,
  output gclt_pkg::char_class_t      head_word
);

  gclt_pkg::char_class_t mem [gclt_pkg::QUEUE_DEPTH];
  logic [gclt_pkg::QPTR_W-1:0] wr_ptr;
  logic [gclt_pkg::QPTR_W-1:0] rd_ptr;
  logic [gclt_pkg::QCNT_W-1:0] count;

  assign full       = (count == gclt_pkg::QCNT_W'(gclt_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_word  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == gclt_pkg::QPTR_W'(gclt_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == gclt_pkg::QPTR_W'(gclt_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/gclt_back.sv
// back end: token state, number accumulation, command lookup and result register
`default_nettype none
module gclt_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   head_valid,
  input  wire gclt_pkg::char_class_t  head_word,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [1:0]                  kind,
  output logic [3:0]                  command,
  output logic [4:0]                  param_index,
  output logic signed [31:0]          mantissa,
  output logic [3:0]                  frac_digits,
  output logic                        overflow,
  output logic                        end_of_line
);

  localparam logic [gclt_pkg::ACC_EXT_W-1:0] MAG_LIMIT =
    (gclt_pkg::ACC_EXT_W'(1) << gclt_pkg::MAG_W) - gclt_pkg::ACC_EXT_W'(1);
  localparam logic [gclt_pkg::CODE_EXT_W-1:0] CODE_MAX =
    gclt_pkg::CODE_EXT_W'({gclt_pkg::CODE_W{1'b1}});

  gclt_pkg::phase_t  phase, phase_next;
  gclt_pkg::letter_t letter, letter_next;
  logic [gclt_pkg::CODE_W-1:0] code_number, code_number_next;
  logic                        negative, negative_next;
  logic                        rejected, rejected_next;
  logic [4:0]                  slot, slot_next;
  logic                        slot_valid, slot_valid_next;
  logic [gclt_pkg::MAG_W-1:0]  accum, accum_next;
  logic                        point_seen, point_seen_next;
  logic [3:0]                  frac_count, frac_count_next;
  logic                        stopped, stopped_next;
  logic                        saturated, saturated_next;

  logic                        emit;
  logic [1:0]                  emit_kind;
  logic [3:0]                  emit_cmd;
  logic [4:0]                  emit_idx;
  logic [31:0]                 emit_mant;
  logic [3:0]                  emit_frac;
  logic                        emit_ovf;
  logic                        emit_eol;

  logic                        skip;
  logic [4:0]                  hit;
  logic [gclt_pkg::ACC_EXT_W-1:0]  acc_ext, acc_sum;
  logic [gclt_pkg::CODE_EXT_W-1:0] code_ext, code_sum;
  logic [31:0]                 mag32;

  // returns {miss, command}
  function automatic logic [4:0] lookup(input gclt_pkg::letter_t l,
                                        input logic [gclt_pkg::CODE_W-1:0] n,
                                        input logic neg);
    logic [4:0] r;
    r = 5'b10000;
    if (!(neg && (n != '0))) begin
      if (l == gclt_pkg::CL_G) begin
        case (n)
          16'd0:   r = {1'b0, gclt_pkg::CMD_G00};
          16'd1:   r = {1'b0, gclt_pkg::CMD_G01};
          16'd4:   r = {1'b0, gclt_pkg::CMD_G04};
          16'd90:  r = {1'b0, gclt_pkg::CMD_G90};
          16'd91:  r = {1'b0, gclt_pkg::CMD_G91};
          16'd92:  r = {1'b0, gclt_pkg::CMD_G92};
          default: r = 5'b10000;
        endcase
      end else if (l == gclt_pkg::CL_M) begin
        case (n)
          16'd3:   r = {1'b0, gclt_pkg::CMD_M03};
          16'd5:   r = {1'b0, gclt_pkg::CMD_M05};
          16'd7:   r = {1'b0, gclt_pkg::CMD_M07};
          16'd9:   r = {1'b0, gclt_pkg::CMD_M09};
          16'd10:  r = {1'b0, gclt_pkg::CMD_M10};
          16'd11:  r = {1'b0, gclt_pkg::CMD_M11};
          16'd14:  r = {1'b0, gclt_pkg::CMD_M14};
          16'd15:  r = {1'b0, gclt_pkg::CMD_M15};
          16'd98:  r = {1'b0, gclt_pkg::CMD_M98};
          16'd99:  r = {1'b0, gclt_pkg::CMD_M99};
          default: r = 5'b10000;
        endcase
      end
    end
    return r;
  endfunction

  assign pop = head_valid && (!out_valid || !out_stall);

  // multiply by ten as shift and add
  assign acc_ext  = {4'b0, accum};
  assign acc_sum  = (acc_ext << 3) + (acc_ext << 1) +
                    gclt_pkg::ACC_EXT_W'(head_word.digit);
  assign code_ext = {4'b0, code_number};
  assign code_sum = (code_ext << 3) + (code_ext << 1) +
                    gclt_pkg::CODE_EXT_W'(head_word.digit);

  always_comb begin
    phase_next      = phase;
    letter_next     = letter;
    code_number_next = code_number;
    negative_next   = negative;
    rejected_next   = rejected;
    slot_next       = slot;
    slot_valid_next = slot_valid;
    accum_next      = accum;
    point_seen_next = point_seen;
    frac_count_next = frac_count;
    stopped_next    = stopped;
    saturated_next  = saturated;
    emit      = 1'b0;
    emit_kind = gclt_pkg::KIND_BARE_EOL;
    emit_cmd  = '0;
    emit_idx  = '0;
    emit_mant = '0;
    emit_frac = '0;
    emit_ovf  = 1'b0;
    emit_eol  = head_word.eol;
    skip      = 1'b0;
    hit       = '0;
    mag32     = '0;

    if (rejected) begin
      if (head_word.eol) begin
        emit = 1'b1;
      end
    end else begin
      if (!head_word.is_space) begin
        case (phase)
          gclt_pkg::PH_FIRST: begin
            letter_next = head_word.is_g ? gclt_pkg::CL_G :
                          head_word.is_m ? gclt_pkg::CL_M : gclt_pkg::CL_OTHER;
            phase_next  = gclt_pkg::PH_CODE_LEAD;
          end
          gclt_pkg::PH_CODE_LEAD, gclt_pkg::PH_CODE_DIGITS: begin
            if (!stopped) begin
              if (phase == gclt_pkg::PH_CODE_LEAD) begin
                if (head_word.is_ws) begin
                  skip = 1'b1;
                end else begin
                  phase_next = gclt_pkg::PH_CODE_DIGITS;
                  if (head_word.is_plus || head_word.is_minus) begin
                    negative_next = head_word.is_minus;
                    skip = 1'b1;
                  end
                end
              end
              if (!skip) begin
                if (!head_word.is_digit) begin
                  stopped_next = 1'b1;
                end else if (!saturated) begin
                  if (code_sum > CODE_MAX) begin
                    code_number_next = {gclt_pkg::CODE_W{1'b1}};
                    saturated_next   = 1'b1;
                  end else begin
                    code_number_next = code_sum[gclt_pkg::CODE_W-1:0];
                  end
                end
              end
            end
          end
          gclt_pkg::PH_PARAM_LETTER: begin
            if (head_word.slot_ok) begin
              slot_next       = head_word.slot;
              slot_valid_next = 1'b1;
            end
            phase_next = gclt_pkg::PH_PARAM_LEAD;
          end
          default: begin
            if (!stopped) begin
              if (phase == gclt_pkg::PH_PARAM_LEAD) begin
                if (head_word.is_ws) begin
                  skip = 1'b1;
                end else begin
                  phase_next = gclt_pkg::PH_PARAM_BODY;
                  if (head_word.is_plus || head_word.is_minus) begin
                    negative_next = head_word.is_minus;
                    skip = 1'b1;
                  end
                end
              end
              if (!skip) begin
                if (head_word.is_point && !point_seen) begin
                  point_seen_next = 1'b1;
                end else if (!head_word.is_digit) begin
                  stopped_next = 1'b1;
                end else if (!saturated && !(point_seen && (frac_count >= 4'd9))) begin
                  if (point_seen) begin
                    frac_count_next = frac_count + 1'b1;
                  end
                  if (acc_sum > MAG_LIMIT) begin
                    accum_next     = MAG_LIMIT[gclt_pkg::MAG_W-1:0];
                    saturated_next = 1'b1;
                  end else begin
                    accum_next = acc_sum[gclt_pkg::MAG_W-1:0];
                  end
                end
              end
            end
          end
        endcase
      end

      if (head_word.is_space || head_word.eol) begin
        if ((phase_next == gclt_pkg::PH_FIRST) || (phase_next == gclt_pkg::PH_CODE_LEAD) ||
            (phase_next == gclt_pkg::PH_CODE_DIGITS)) begin
          hit      = lookup(letter_next, code_number_next, negative_next);
          emit     = 1'b1;
          emit_ovf = saturated_next;
          if (!hit[4]) begin
            emit_kind        = gclt_pkg::KIND_CMD_OK;
            emit_cmd         = hit[3:0];
            phase_next       = gclt_pkg::PH_PARAM_LETTER;
            code_number_next = '0;
            negative_next    = 1'b0;
            slot_next        = '0;
            slot_valid_next  = 1'b0;
            accum_next       = '0;
            point_seen_next  = 1'b0;
            frac_count_next  = '0;
            stopped_next     = 1'b0;
            saturated_next   = 1'b0;
          end else begin
            emit_kind     = gclt_pkg::KIND_CMD_REJ;
            rejected_next = 1'b1;
          end
        end else begin
          if ((phase_next != gclt_pkg::PH_PARAM_LETTER) && slot_valid_next) begin
            mag32     = 32'(accum_next);
            emit      = 1'b1;
            emit_kind = gclt_pkg::KIND_PARAM;
            emit_idx  = slot_next;
            emit_mant = negative_next ? (32'd0 - mag32) : mag32;
            emit_frac = frac_count_next;
            emit_ovf  = saturated_next;
          end else if (head_word.eol) begin
            emit = 1'b1;
          end
          phase_next       = gclt_pkg::PH_PARAM_LETTER;
          code_number_next = '0;
          negative_next    = 1'b0;
          slot_next        = '0;
          slot_valid_next  = 1'b0;
          accum_next       = '0;
          point_seen_next  = 1'b0;
          frac_count_next  = '0;
          stopped_next     = 1'b0;
          saturated_next   = 1'b0;
        end
      end
    end

    // end of line returns everything to the start of a line
    if (head_word.eol) begin
      phase_next       = gclt_pkg::PH_FIRST;
      letter_next      = gclt_pkg::CL_NONE;
      rejected_next    = 1'b0;
      code_number_next = '0;
      negative_next    = 1'b0;
      slot_next        = '0;
      slot_valid_next  = 1'b0;
      accum_next       = '0;
      point_seen_next  = 1'b0;
      frac_count_next  = '0;
      stopped_next     = 1'b0;
      saturated_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= gclt_pkg::PH_FIRST;
      letter      <= gclt_pkg::CL_NONE;
      code_number <= '0;
      negative    <= 1'b0;
      rejected    <= 1'b0;
      slot        <= '0;
      slot_valid  <= 1'b0;
      accum       <= '0;
      point_seen  <= 1'b0;
      frac_count  <= '0;
      stopped     <= 1'b0;
      saturated   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        phase       <= phase_next;
        letter      <= letter_next;
        code_number <= code_number_next;
        negative    <= negative_next;
        rejected    <= rejected_next;
        slot        <= slot_next;
        slot_valid  <= slot_valid_next;
        accum       <= accum_next;
        point_seen  <= point_seen_next;
        frac_count  <= frac_count_next;
        stopped     <= stopped_next;
        saturated   <= saturated_next;
      end
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      kind        <= emit_kind;
      command     <= emit_cmd;
      param_index <= emit_idx;
      mantissa    <= emit_mant;
      frac_digits <= emit_frac;
      overflow    <= emit_ovf;
      end_of_line <= emit_eol;
    end
  end

endmodule
`default_nettype wire

### sv/gcode_line_tokenizer.sv
// top level of the g-code line tokenizer
// usage:
//   input channel: one character word per handshake (char_in, line_end), accepted
//   when in_valid is high and in_stall is low; line_end marks the last character
//   output channel: zero or one result word per character (kind, command,
//   param_index, mantissa, frac_digits, overflow, end_of_line), taken when
//   out_valid is high and out_stall is low
//   a line is split on single spaces; the first token gives a command or a
//   rejection, later tokens give parameter results, a line end that yields
//   nothing else gives a bare end-of-line result
// path: an accepted character word is written into the queue; the back end pops it
//   once no stalled result is held, and any result it causes is registered at the
//   same edge as the pop
// throughput: one character per cycle while out_stall is low, set by the back end, which
//   handles one character per cycle with a single multiply-by-ten accumulate and compare
// reset: rst is synchronous; it empties the two-entry queue, drops any waiting
//   result and returns the tokenizer to the start of a line
// stall: while out_stall holds a result, the back end stops, the queue fills and
//   in_stall rises once the queue holds two words
`default_nettype none
module gcode_line_tokenizer (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           char_in,
  input  wire logic                 line_end,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                kind,
  output logic [3:0]                command,
  output logic [4:0]                param_index,
  output logic signed [31:0]        mantissa,
  output logic [3:0]                frac_digits,
  output logic                      overflow,
  output logic                      end_of_line
);

  gclt_pkg::char_class_t cls;
  gclt_pkg::char_class_t head_word;
  logic                  head_valid;
  logic                  pop;
  logic                  full;

  assign in_stall = full;

  gclt_front u_front (
    .char_in  (char_in),
    .line_end (line_end),
    .cls      (cls)
  );

  gclt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid && !full),
    .push_word  (cls),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_word  (head_word)
  );

  gclt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_word   (head_word),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .command     (command),
    .param_index (param_index),
    .mantissa    (mantissa),
    .frac_digits (frac_digits),
    .overflow    (overflow),
    .end_of_line (end_of_line)
  );

endmodule
`default_nettype wire

### sv/gclt_checker.sv
// port-level checks for the g-code line tokenizer and their bind
`default_nettype none
module gclt_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic [7:0]        char_in,
  input wire logic              line_end,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [1:0]        kind,
  input wire logic [3:0]        command,
  input wire logic [4:0]        param_index,
  input wire logic signed [31:0] mantissa,
  input wire logic [3:0]        frac_digits,
  input wire logic              overflow,
  input wire logic              end_of_line
);

  // a stalled result word stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(mantissa))
    else $error("result word dropped while stalled");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // only parameter words carry a value
  a_value_only_param: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != gclt_pkg::KIND_PARAM) |->
      (param_index == '0) && (mantissa == '0) && (frac_digits == '0))
    else $error("value fields set on a non-parameter word");

  // bare end of line closes the line and carries nothing else
  a_bare_eol: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == gclt_pkg::KIND_BARE_EOL) |->
      end_of_line && !overflow && (command == '0))
    else $error("malformed bare end-of-line word");

  // fraction count never runs past nine
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frac_digits <= 4'd9))
    else $error("fraction digit count out of range");

endmodule

bind gcode_line_tokenizer gclt_checker u_gclt_checker (.*);
`default_nettype wire

### verif/gcode_line_tokenizer_tb.sv
// self-checking testbench for the g-code line tokenizer: directed and random lines
`timescale 1ns / 1ps
`default_nettype none
module gcode_line_tokenizer_tb;
  import gclt_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_LIMIT = 500;
  localparam int TAIL_CYCLES = 10;
  localparam int RANDOM_CHARS = 360;
  localparam int QUIET_CHARS = 120;
  localparam longint unsigned MAG_LIMIT =
    (MANTISSA_BITS >= 2 && MANTISSA_BITS < 32) ? (64'd1 << (MANTISSA_BITS - 1)) - 64'd1
                                               : 64'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  command;
    logic [4:0]  idx;
    logic [31:0] mant;
    logic [3:0]  frac;
    logic        ovf;
    logic        eol;
  } token_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         char_in = 8'd0;
  logic               line_end = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         kind;
  logic [3:0]         command;
  logic [4:0]         param_index;
  logic signed [31:0] mantissa;
  logic [3:0]         frac_digits;
  logic               overflow;
  logic               end_of_line;

  gcode_line_tokenizer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .char_in(char_in), .line_end(line_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .command(command), .param_index(param_index), .mantissa(mantissa),
    .frac_digits(frac_digits), .overflow(overflow), .end_of_line(end_of_line)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  token_t     expected_tokens[$];
  logic [7:0] line_chars[$];
  int         fail_count = 0;
  int         chars_sent = 0;
  int         stall_left = 0;
  int         quiet_cycles = 0;
  logic       idle_on = 1'b1;

  // tokenizer state
  phase_t      tok_phase;
  letter_t     tok_letter;
  logic [15:0] tok_code;
  logic        tok_neg;
  logic        tok_rejected;
  logic [4:0]  tok_slot;
  logic        tok_slot_ok;
  logic [31:0] tok_accum;
  logic        tok_point;
  logic [3:0]  tok_frac;
  logic        tok_stopped;
  logic        tok_sat;

  function automatic void clear_number_state();
    tok_code = '0; tok_neg = 1'b0; tok_slot = '0; tok_slot_ok = 1'b0;
    tok_accum = '0; tok_point = 1'b0; tok_frac = '0; tok_stopped = 1'b0; tok_sat = 1'b0;
  endfunction

  function automatic void clear_line_state();
    tok_phase = PH_FIRST;
    tok_letter = CL_NONE;
    tok_rejected = 1'b0;
    clear_number_state();
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_ws(input logic [7:0] c);
    return c >= CH_TAB && c <= CH_CR;
  endfunction

  function automatic bit lookup_command(output cmd_t cmd);
    cmd = CMD_G00;
    if (tok_neg && tok_code != 16'd0) return 1'b0;
    if (tok_letter == CL_G) begin
      case (tok_code)
        16'd0:  cmd = CMD_G00;
        16'd1:  cmd = CMD_G01;
        16'd4:  cmd = CMD_G04;
        16'd90: cmd = CMD_G90;
        16'd91: cmd = CMD_G91;
        16'd92: cmd = CMD_G92;
        default: return 1'b0;
      endcase
    end else if (tok_letter == CL_M) begin
      case (tok_code)
        16'd3:  cmd = CMD_M03;
        16'd5:  cmd = CMD_M05;
        16'd7:  cmd = CMD_M07;
        16'd9:  cmd = CMD_M09;
        16'd10: cmd = CMD_M10;
        16'd11: cmd = CMD_M11;
        16'd14: cmd = CMD_M14;
        16'd15: cmd = CMD_M15;
        16'd98: cmd = CMD_M98;
        16'd99: cmd = CMD_M99;
        default: return 1'b0;
      endcase
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void feed_code(input logic [7:0] c);
    logic [31:0] v;
    if (tok_stopped) return;
    if (tok_phase == PH_CODE_LEAD) begin
      if (is_ws(c)) return;
      tok_phase = PH_CODE_DIGITS;
      if (c == CH_PLUS || c == CH_MINUS) begin
        tok_neg = (c == CH_MINUS);
        return;
      end
    end
    if (!is_digit(c)) begin
      tok_stopped = 1'b1;
      return;
    end
    if (tok_sat) return;
    v = 32'(tok_code) * 32'd10 + 32'(c - CH_ZERO);
    if (v > 32'd65535) begin
      tok_code = 16'hFFFF;
      tok_sat = 1'b1;
    end else begin
      tok_code = v[15:0];
    end
  endfunction

  function automatic void feed_param(input logic [7:0] c);
    logic [63:0] v;
    if (tok_stopped) return;
    if (tok_phase == PH_PARAM_LEAD) begin
      if (is_ws(c)) return;
      tok_phase = PH_PARAM_BODY;
      if (c == CH_PLUS || c == CH_MINUS) begin
        tok_neg = (c == CH_MINUS);
        return;
      end
    end
    if (c == CH_POINT && !tok_point) begin
      tok_point = 1'b1;
      return;
    end
    if (!is_digit(c)) begin
      tok_stopped = 1'b1;
      return;
    end
    if (tok_sat) return;
    if (tok_point) begin
      if (tok_frac >= 4'd9) return;
      tok_frac = tok_frac + 4'd1;
    end
    v = 64'(tok_accum) * 64'd10 + 64'(c - CH_ZERO);
    if (v > MAG_LIMIT) begin
      v = MAG_LIMIT;
      tok_sat = 1'b1;
    end
    tok_accum = v[31:0];
  endfunction

  function automatic bit tokenize_char(input logic [7:0] c, input logic eol, output token_t r);
    bit   is_space;
    cmd_t cmd;
    r = '0;
    is_space = (c == CH_SPACE);
    if (tok_rejected) begin
      if (!eol) return 1'b0;
      r.kind = KIND_BARE_EOL;
      r.eol = 1'b1;
      clear_line_state();
      return 1'b1;
    end
    if (!is_space) begin
      case (tok_phase)
        PH_FIRST: begin
          tok_letter = (c == CH_G) ? CL_G : (c == CH_M) ? CL_M : CL_OTHER;
          tok_phase = PH_CODE_LEAD;
        end
        PH_CODE_LEAD, PH_CODE_DIGITS: feed_code(c);
        PH_PARAM_LETTER: begin
          if (c >= CH_A && (32'(c) - 32'(CH_A)) < LETTER_SLOTS) begin
            tok_slot = 5'(c - CH_A);
            tok_slot_ok = 1'b1;
          end
          tok_phase = PH_PARAM_LEAD;
        end
        default: feed_param(c);
      endcase
    end
    if (!is_space && !eol) return 1'b0;
    if (tok_phase == PH_FIRST || tok_phase == PH_CODE_LEAD || tok_phase == PH_CODE_DIGITS) begin
      r.ovf = tok_sat;
      r.eol = eol;
      if (lookup_command(cmd)) begin
        r.kind = KIND_CMD_OK;
        r.command = cmd;
        clear_number_state();
        tok_phase = PH_PARAM_LETTER;
      end else begin
        r.kind = KIND_CMD_REJ;
        tok_rejected = 1'b1;
      end
      if (eol) clear_line_state();
      return 1'b1;
    end
    if (tok_phase != PH_PARAM_LETTER && tok_slot_ok) begin
      r.kind = KIND_PARAM;
      r.idx = tok_slot;
      r.mant = tok_neg ? (32'd0 - tok_accum) : tok_accum;
      r.frac = tok_frac;
      r.ovf = tok_sat;
      r.eol = eol;
    end else if (eol) begin
      r.kind = KIND_BARE_EOL;
      r.eol = 1'b1;
    end else begin
      clear_number_state();
      tok_phase = PH_PARAM_LETTER;
      return 1'b0;
    end
    clear_number_state();
    tok_phase = PH_PARAM_LETTER;
    if (eol) clear_line_state();
    return 1'b1;
  endfunction

  // output side: random stall bursts
  always @(posedge clk) begin : stall_gen
    int n;
    if (stall_left > 0) n = stall_left - 1;
    else if (idle_on && $urandom_range(0, 7) == 0) n = $urandom_range(1, 11);
    else n = 0;
    stall_left <= n;
    out_stall <= (n != 0);
  end

  always @(posedge clk) begin : result_check
    token_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected result word, kind %0d", kind);
        fail_count++;
      end else begin
        e = expected_tokens.pop_front();
        if (kind !== e.kind) begin
          $error("kind expected %0d got %0d", e.kind, kind);
          fail_count++;
        end
        if (command !== e.command) begin
          $error("command expected %0d got %0d", e.command, command);
          fail_count++;
        end
        if (param_index !== e.idx) begin
          $error("param_index expected %0d got %0d", e.idx, param_index);
          fail_count++;
        end
        if (mantissa !== e.mant) begin
          $error("mantissa expected %0d got %0d", $signed(e.mant), mantissa);
          fail_count++;
        end
        if (frac_digits !== e.frac) begin
          $error("frac_digits expected %0d got %0d", e.frac, frac_digits);
          fail_count++;
        end
        if (overflow !== e.ovf) begin
          $error("overflow expected %0d got %0d", e.ovf, overflow);
          fail_count++;
        end
        if (end_of_line !== e.eol) begin
          $error("end_of_line expected %0d got %0d", e.eol, end_of_line);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic eol);
    token_t r;
    int     gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in <= c;
    line_end <= eol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (tokenize_char(c, eol, r)) expected_tokens.push_back(r);
    chars_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_chars.size(); i++) send_char(line_chars[i], i == line_chars.size() - 1);
    line_chars.delete();
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_chars.push_back(s[i]);
  endfunction

  function automatic void push_digits(input int count);
    repeat (count) line_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  task automatic send_text(input string s);
    push_text(s);
    send_line();
  endtask

  function automatic void command_code(input cmd_t c, output logic [7:0] letter, output int num);
    letter = CH_M;
    case (c)
      CMD_G00: begin letter = CH_G; num = 0; end
      CMD_G01: begin letter = CH_G; num = 1; end
      CMD_G04: begin letter = CH_G; num = 4; end
      CMD_G90: begin letter = CH_G; num = 90; end
      CMD_G91: begin letter = CH_G; num = 91; end
      CMD_G92: begin letter = CH_G; num = 92; end
      CMD_M03: num = 3;
      CMD_M05: num = 5;
      CMD_M07: num = 7;
      CMD_M09: num = 9;
      CMD_M10: num = 10;
      CMD_M11: num = 11;
      CMD_M14: num = 14;
      CMD_M15: num = 15;
      CMD_M98: num = 98;
      default: num = 99;
    endcase
  endfunction

  function automatic void build_random_line(input int line_no);
    logic [7:0] letter;
    int         num;
    int         n_params;
    if ($urandom_range(0, 19) == 0) begin
      // pure noise
      repeat ($urandom_range(1, 10)) line_chars.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 6) != 0) begin
      command_code(cmd_t'(line_no < 16 ? line_no : $urandom_range(0, 15)), letter, num);
      line_chars.push_back(letter);
      if ($urandom_range(0, 9) == 0) line_chars.push_back(8'($urandom_range(9, 13)));
      if ($urandom_range(0, 9) == 0) line_chars.push_back(CH_PLUS);
      if (num == 0 && $urandom_range(0, 3) == 0) line_chars.push_back(CH_MINUS);
      repeat ($urandom_range(0, 2)) line_chars.push_back(CH_ZERO);
      if (num != 0 || $urandom_range(0, 4) != 0) push_text($sformatf("%0d", num));
    end else begin
      case ($urandom_range(0, 3))
        0: line_chars.push_back(CH_G);
        1: line_chars.push_back(CH_M);
        2: line_chars.push_back(8'($urandom_range(97, 122)));
        default: line_chars.push_back(8'($urandom_range(0, 255)));
      endcase
      if ($urandom_range(0, 3) == 0) line_chars.push_back(CH_MINUS);
      push_text($sformatf("%0d", $urandom_range(0, 99999)));
    end
    n_params = $urandom_range(0, 4);
    repeat (n_params) begin
      line_chars.push_back(CH_SPACE);
      if ($urandom_range(0, 14) == 0) line_chars.push_back(CH_SPACE);
      if ($urandom_range(0, 6) != 0) line_chars.push_back(CH_A + 8'($urandom_range(0, 25)));
      else line_chars.push_back(8'($urandom_range(33, 255)));
      if ($urandom_range(0, 9) == 0) line_chars.push_back(8'($urandom_range(9, 13)));
      case ($urandom_range(0, 5))
        0: line_chars.push_back(CH_PLUS);
        1: line_chars.push_back(CH_MINUS);
        default: ;
      endcase
      push_digits($urandom_range(0, 9) == 0 ? $urandom_range(8, 13) : $urandom_range(0, 4));
      if ($urandom_range(0, 1) == 0) begin
        line_chars.push_back(CH_POINT);
        push_digits($urandom_range(0, 9) == 0 ? $urandom_range(8, 13) : $urandom_range(0, 4));
      end
      if ($urandom_range(0, 9) == 0) line_chars.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 19) == 0) line_chars.push_back(CH_SPACE);
  endfunction

  task automatic test_code_token_cases();
    send_text("G");
    send_text("G-0 X");
    send_text("M\t+15");
    send_text("G65536 Y2");
    send_text("M-5 X1");
    send_text("g1");
    send_text(" ");
    send_text("M7x Y3");
  endtask

  task automatic test_param_token_cases();
    send_text("G1 Z2147483647 A-99999999999 B.1234567890123");
    send_text("M99 C12.5.6 D\t-7 E @5 a5  ");
  endtask

  task automatic test_control_chars();
    line_chars.push_back(8'h00);
    send_line();
    push_text("G0 ");
    line_chars.push_back(8'hFF);
    push_text("1 Q");
    line_chars.push_back(8'h00);
    push_text(" R-");
    line_chars.push_back(8'h7F);
    send_line();
  endtask

  task automatic test_random_lines();
    int line_no;
    line_no = 0;
    while (chars_sent < RANDOM_CHARS) begin
      idle_on <= ($urandom_range(0, 4) != 0);
      build_random_line(line_no);
      send_line();
      line_no++;
    end
  endtask

  task automatic test_back_to_back_lines();
    int target;
    target = chars_sent + QUIET_CHARS;
    idle_on <= 1'b0;
    while (chars_sent < target) begin
      build_random_line(16);
      send_line();
    end
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_tokens.size() != 0) begin
      $error("%0d result words never arrived", expected_tokens.size());
      fail_count++;
    end
  endtask

  initial begin
    clear_line_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_code_token_cases();
    test_param_token_cases();
    test_control_chars();
    test_random_lines();
    test_back_to_back_lines();
    wait_drained();
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
sv/gclt_pkg.sv
sv/gclt_front.sv
sv/gclt_queue.sv
sv/gclt_back.sv
sv/gcode_line_tokenizer.sv
sv/gclt_checker.sv
verif/gcode_line_tokenizer_tb.sv
